FILE: rtl/core/sofrx_pkg.sv
// sofrx_pkg: types, codes and constants shared by the frame receiver modules
// no dependencies

package sofrx_pkg;

   // received length is cut to this many bits, 8 to 16
   localparam int LENGTH_BITS = 16;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 8;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_ONE = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_TWO = 1'b1;

   localparam logic [7:0] START_ONE_RESET = 8'd170;
   localparam logic [7:0] START_TWO_RESET = 8'd85;

   // input item kinds
   localparam logic KIND_BYTE    = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   // result kinds
   localparam logic RES_PAYLOAD   = 1'b0;
   localparam logic RES_FRAME_END = 1'b1;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_SECOND  = 3'd1,
      PH_LEN_HI  = 3'd2,
      PH_LEN_LO  = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_CK_HI   = 3'd5,
      PH_CK_LO   = 3'd6,
      PH_HELD    = 3'd7
   } phase_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] rx_byte;
   } item_type;

   typedef struct packed {
      logic       result_kind;
      logic [7:0] payload_byte;
      logic       frame_good;
   } result_type;

endpackage

FILE: rtl/core/sofrx_in_stage.sv
// sofrx_in_stage: input register for one received beat
// depends on sofrx_pkg

module sofrx_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  sofrx_pkg::item_type req_item,
   input  logic               slot_free,
   output sofrx_pkg::item_type item,
   output logic               advance
);
   import sofrx_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     req_fire;

   assign advance    = valid_ff && slot_free;
   assign req_tready = !valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;
   assign item       = item_ff;

   always_comb begin
      priority if (req_fire) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= req_item;
      end
   end

`ifndef SYNTHESIS
   // a beat taken into a full stage must push the held one on in the same cycle
   assert property (@(posedge clock) disable iff (reset)
      req_fire && valid_ff |-> advance)
      else $error("sofrx_in_stage: held beat overwritten");

   // a held beat that cannot move stays held
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && !slot_free |=> valid_ff && $stable(item_ff))
      else $error("sofrx_in_stage: held beat lost");

   // with the stage empty nothing goes downstream
   assert property (@(posedge clock) disable iff (reset)
      !valid_ff |-> !advance)
      else $error("sofrx_in_stage: advance without a beat");
`endif

endmodule

FILE: rtl/core/sofrx_parse.sv
// sofrx_parse: start byte registers and the frame parsing state machine
// depends on sofrx_pkg

module sofrx_parse (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [sofrx_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [sofrx_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  logic                                   advance,
   input  sofrx_pkg::item_type                    item,
   output logic                                   res_valid,
   output sofrx_pkg::result_type                  res
);
   import sofrx_pkg::*;

   logic [7:0]             start_one_ff;
   logic [7:0]             start_two_ff;
   phase_type              phase_ff;
   phase_type              phase_in;
   logic [LENGTH_BITS-1:0] bytes_left_ff;
   logic [LENGTH_BITS-1:0] bytes_left_in;
   logic [7:0]             length_high_ff;
   logic [7:0]             length_high_in;
   logic [7:0]             checksum_high_ff;
   logic [7:0]             checksum_high_in;
   logic [15:0]            length_full;
   logic [LENGTH_BITS-1:0] length_cut;
   logic                   checksum_zero;

   assign length_full   = {length_high_ff, item.rx_byte};
   assign length_cut    = length_full[LENGTH_BITS-1:0];
   assign checksum_zero = ({checksum_high_ff, item.rx_byte} == 16'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         start_one_ff <= START_ONE_RESET;
         start_two_ff <= START_TWO_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_START_ONE: start_one_ff <= csr_wdata;
            CSR_START_TWO: start_two_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         bytes_left_ff <= '0;
      end else begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_high_ff   <= '0;
         checksum_high_ff <= '0;
      end else begin
         length_high_ff   <= length_high_in;
         checksum_high_ff <= checksum_high_in;
      end
   end

   always_comb begin
      phase_in              = phase_ff;
      bytes_left_in         = bytes_left_ff;
      length_high_in        = length_high_ff;
      checksum_high_in      = checksum_high_ff;
      res_valid             = 1'b0;
      res.result_kind       = RES_PAYLOAD;
      res.payload_byte      = 8'd0;
      res.frame_good        = 1'b0;
      if (advance) begin
         if (item.kind == KIND_RELEASE) begin
            if (phase_ff == PH_HELD) begin
               phase_in = PH_HUNT;
            end
         end else begin
            unique case (phase_ff)
               PH_HUNT: begin
                  if (item.rx_byte == start_one_ff) begin
                     phase_in = PH_SECOND;
                  end
               end
               PH_SECOND: begin
                  phase_in = (item.rx_byte == start_two_ff) ? PH_LEN_HI : PH_HUNT;
               end
               PH_LEN_HI: begin
                  length_high_in = item.rx_byte;
                  phase_in       = PH_LEN_LO;
               end
               PH_LEN_LO: begin
                  bytes_left_in = length_cut;
                  // empty payload goes straight to the checksum
                  phase_in = (length_cut == '0) ? PH_CK_HI : PH_PAYLOAD;
               end
               PH_PAYLOAD: begin
                  bytes_left_in = bytes_left_ff - LENGTH_BITS'(1);
                  if (bytes_left_ff == LENGTH_BITS'(1)) begin
                     phase_in = PH_CK_HI;
                  end
                  res_valid        = 1'b1;
                  res.payload_byte = item.rx_byte;
               end
               PH_CK_HI: begin
                  checksum_high_in = item.rx_byte;
                  phase_in         = PH_CK_LO;
               end
               PH_CK_LO: begin
                  res_valid       = 1'b1;
                  res.result_kind = RES_FRAME_END;
                  res.frame_good  = checksum_zero;
                  phase_in        = checksum_zero ? PH_HELD : PH_HUNT;
               end
               PH_HELD: ;
               default: ;
            endcase
         end
      end
   end

`ifndef SYNTHESIS
   // payload phase always has bytes still to come
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> bytes_left_ff != '0)
      else $error("sofrx_parse: payload phase with no bytes left");

   // a good frame end leaves the block holding
   assert property (@(posedge clock) disable iff (reset)
      res_valid && res.result_kind == RES_FRAME_END && res.frame_good
      |=> phase_ff == PH_HELD)
      else $error("sofrx_parse: good frame not held");

   // release of a held frame goes back to hunting
   assert property (@(posedge clock) disable iff (reset)
      advance && item.kind == KIND_RELEASE && phase_ff == PH_HELD
      |=> phase_ff == PH_HUNT)
      else $error("sofrx_parse: release ignored");

   // while holding, nothing comes out
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HELD |-> !res_valid)
      else $error("sofrx_parse: result while holding");
`endif

endmodule

FILE: rtl/core/sofrx_out_stage.sv
// sofrx_out_stage: result register toward the rsp channel
// depends on sofrx_pkg

module sofrx_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  res_valid,
   input  sofrx_pkg::result_type res,
   output logic                  slot_free,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output sofrx_pkg::result_type rsp_result
);
   import sofrx_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   assign slot_free  = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_result = result_ff;

   always_comb begin
      priority if (res_valid) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         result_ff <= res;
      end
   end

`ifndef SYNTHESIS
   // a new result only lands in a free slot
   assert property (@(posedge clock) disable iff (reset)
      res_valid |-> slot_free)
      else $error("sofrx_out_stage: result dropped");

   // payload results never flag a good frame
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && result_ff.result_kind == RES_PAYLOAD |-> !result_ff.frame_good)
      else $error("sofrx_out_stage: payload beat marked good");

   // frame end results carry a zero byte
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && result_ff.result_kind == RES_FRAME_END
      |-> result_ff.payload_byte == 8'd0)
      else $error("sofrx_out_stage: frame end with data");
`endif

endmodule

FILE: rtl/core/sof_length_frame_receiver.sv
// sof_length_frame_receiver: start byte / length / payload / checksum deframer
// depends on sofrx_pkg, sofrx_in_stage, sofrx_parse, sofrx_out_stage
//
//   channel | dir | tdata                      | tuser
//   req_    | in  | [7:0] rx_byte              | [0] kind (1 = release)
//   rsp_    | out | [7:0] payload_byte, [8]    | [0] result_kind (1 = frame end)
//           |     | frame_good, [15:9] zero    |
//   csr_    | in  | write: index 0 start_byte_one, 1 start_byte_two
//
// one beat per cycle sustained while rsp is not stalled; a result is held in the
// input register and then in the result register before it leaves on rsp
// the parser decides each beat combinationally from its phase register
// synchronous active-high reset: hunting for the first start byte, start
// bytes back to 0xaa and 0x55
// a stall on rsp holds the result register and then the input register;
// req_tready drops only when both are full

module sof_length_frame_receiver (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,   // [7:0] rx_byte
   input  logic                                 req_tuser,   // [0] kind
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [15:0]                          rsp_tdata,   // [7:0] payload_byte, [8] frame_good
   output logic                                 rsp_tuser,   // [0] result_kind
   input  logic                                 csr_we,
   input  logic [sofrx_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sofrx_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import sofrx_pkg::*;

   item_type   req_item;
   item_type   item;
   logic       advance;
   logic       slot_free;
   logic       res_valid;
   result_type res;
   result_type rsp_result;

   assign req_item.kind    = req_tuser;
   assign req_item.rx_byte = req_tdata;

   assign rsp_tdata = {7'd0, rsp_result.frame_good, rsp_result.payload_byte};
   assign rsp_tuser = rsp_result.result_kind;

   sofrx_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .slot_free  (slot_free),
      .item       (item),
      .advance    (advance)
   );

   sofrx_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .advance   (advance),
      .item      (item),
      .res_valid (res_valid),
      .res       (res)
   );

   sofrx_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res        (res),
      .slot_free  (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (rsp_result)
   );

endmodule

FILE: tb/sof_length_frame_receiver_test.sv
// sof_length_frame_receiver_test: self-checking bench for the start byte / length /
// payload / checksum deframer; a directed table, then random frames under four idling phases
// depends on sofrx_pkg and sof_length_frame_receiver
`timescale 1ns / 100ps

module sof_length_frame_receiver_test;
   import sofrx_pkg::*;

   localparam int          MAX_REPORTS   = 10;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          DRAIN_LIMIT   = 5000;
   localparam int          PHASE_ITEMS   = 225;
   localparam longint      RUN_LIMIT_NS  = 2_000_000;
   localparam logic [15:0] LENGTH_MASK   = 16'((32'd1 << LENGTH_BITS) - 32'd1);

   typedef enum {CHECK_PREDICTED, CHECK_NONE, CHECK_GIVEN} row_check_type;

   typedef struct {
      logic          kind;
      logic [7:0]    data;
      row_check_type check;
      result_type    given;
   } script_row_type;

   logic                      clock;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata  = 8'h00;   // [7:0] rx_byte
   logic                      req_tuser  = 1'b0;    // [0] kind
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [15:0]               rsp_tdata;            // [7:0] payload_byte, [8] frame_good
   logic                      rsp_tuser;            // [0] result_kind
   logic                      csr_we     = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index  = CSR_START_ONE;
   logic [CSR_DATA_BITS-1:0]  csr_wdata  = '0;

   // deframer state as the bench sees it
   phase_type   rx_phase      = PH_HUNT;
   logic [15:0] rx_bytes_left = '0;
   logic [7:0]  rx_length_hi  = '0;
   logic [7:0]  rx_ck_hi      = '0;
   logic [7:0]  rx_start_one  = START_ONE_RESET;
   logic [7:0]  rx_start_two  = START_TWO_RESET;

   result_type     expected_results[$];
   script_row_type script[$];
   int             mismatches    = 0;
   int             items_counted = 0;
   int             send_idle_pct = 0;
   int             recv_stall_pct = 0;
   int             hold_cycles   = 0;

   sof_length_frame_receiver u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("== FAIL ==");
      $finish;
   end

   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch at %0t: %s", $time, msg);
   endtask

   // one beat through the deframer: returns whether it yields a result and what
   task automatic deframe_beat(input logic kind, input logic [7:0] b,
                               output bit has_result, output result_type res);
      logic [15:0] sum;
      has_result = 1'b0;
      res        = '0;
      if (kind == KIND_RELEASE) begin
         if (rx_phase == PH_HELD)
            rx_phase = PH_HUNT;
         return;
      end
      case (rx_phase)
         PH_HUNT: begin
            if (b == rx_start_one) begin
               rx_bytes_left = '0;
               rx_length_hi  = '0;
               rx_ck_hi      = '0;
               rx_phase      = PH_SECOND;
            end
         end
         PH_SECOND: rx_phase = (b == rx_start_two) ? PH_LEN_HI : PH_HUNT;
         PH_LEN_HI: begin
            rx_length_hi = b;
            rx_phase     = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            rx_bytes_left = {rx_length_hi, b} & LENGTH_MASK;
            // zero length skips straight to the checksum
            rx_phase = (rx_bytes_left == 16'd0) ? PH_CK_HI : PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            rx_bytes_left = rx_bytes_left - 16'd1;
            if (rx_bytes_left == 16'd0)
               rx_phase = PH_CK_HI;
            has_result       = 1'b1;
            res.result_kind  = RES_PAYLOAD;
            res.payload_byte = b;
         end
         PH_CK_HI: begin
            rx_ck_hi = b;
            rx_phase = PH_CK_LO;
         end
         PH_CK_LO: begin
            sum             = {rx_ck_hi, b};
            has_result      = 1'b1;
            res.result_kind = RES_FRAME_END;
            res.frame_good  = (sum == 16'd0);
            rx_phase        = (sum == 16'd0) ? PH_HELD : PH_HUNT;
         end
         default: ;   // holding: bytes are dropped
      endcase
   endtask

   // offers one beat, waits for the handshake, then steps the deframer state
   task automatic send_beat(input logic kind, input logic [7:0] data,
                            output bit has_result, output result_type res);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      if ((kind == KIND_BYTE) ? (rx_phase != PH_HELD) : (rx_phase == PH_HELD))
         items_counted++;
      deframe_beat(kind, data, has_result, res);
   endtask

   task automatic send_checked(input logic kind, input logic [7:0] data);
      bit         has_result;
      result_type res;
      send_beat(kind, data, has_result, res);
      if (has_result)
         expected_results = {expected_results, res};
   endtask

   // lowers valid and waits out every expected result, bounded
   task automatic wait_drained();
      int n;
      req_tvalid <= 1'b0;
      @(posedge clock);
      for (n = 0; n < DRAIN_LIMIT && expected_results.size() != 0; n++)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_start_bytes(input logic [7:0] one, input logic [7:0] two);
      csr_we    <= 1'b1;
      csr_index <= CSR_START_ONE;
      csr_wdata <= one;
      @(posedge clock);
      csr_index <= CSR_START_TWO;
      csr_wdata <= two;
      @(posedge clock);
      csr_we       <= 1'b0;
      rx_start_one = one;
      rx_start_two = two;
   endtask

   // keeps the length high byte small so a broken header cannot start a huge frame
   function automatic logic [7:0] noise_byte();
      logic [7:0] b;
      b = (rx_phase == PH_LEN_HI) ? 8'($urandom_range(1)) : 8'($urandom);
      return b;
   endfunction

   task automatic send_frame();
      logic [15:0] len;
      logic [15:0] sum;
      int          pick;
      pick = $urandom_range(99);
      if (pick < 10)
         len = 16'd0;
      else if (pick < 13)
         len = 16'($urandom_range(256, 300));
      else
         len = 16'($urandom_range(1, 16));
      send_checked(KIND_BYTE, rx_start_one);
      send_checked(KIND_BYTE, rx_start_two);
      send_checked(KIND_BYTE, len[15:8]);
      send_checked(KIND_BYTE, len[7:0]);
      repeat (len) send_checked(KIND_BYTE, 8'($urandom));
      pick = $urandom_range(99);
      if (pick < 60)
         sum = 16'd0;
      else if (pick < 75)
         sum = {8'h00, 8'($urandom_range(1, 255))};
      else if (pick < 90)
         sum = {8'($urandom_range(1, 255)), 8'h00};
      else
         sum = 16'($urandom);
      send_checked(KIND_BYTE, sum[15:8]);
      send_checked(KIND_BYTE, sum[7:0]);
   endtask

   task automatic send_noise();
      int count;
      count = $urandom_range(1, 8);
      if ($urandom_range(99) < 30)
         send_checked(KIND_BYTE, rx_start_one);
      repeat (count)
         send_checked(($urandom_range(9) == 0) ? KIND_RELEASE : KIND_BYTE, noise_byte());
   endtask

   task automatic random_step();
      if (rx_phase == PH_HELD) begin
         repeat ($urandom_range(0, 2)) send_checked(KIND_BYTE, 8'($urandom));
         send_checked(KIND_RELEASE, 8'($urandom));
      end else if (rx_phase != PH_HUNT) begin
         // left mid-frame by noise: keep feeding until the frame closes
         send_checked(KIND_BYTE, noise_byte());
      end else if ($urandom_range(99) < 80) begin
         send_frame();
      end else begin
         send_noise();
      end
   endtask

   task automatic run_random(input int target);
      while (items_counted < target)
         random_step();
   endtask

   task automatic add_row(input logic kind, input logic [7:0] data, input row_check_type check,
                          input logic rkind = 1'b0, input logic [7:0] rbyte = 8'h00,
                          input logic rgood = 1'b0);
      script_row_type row;
      row.kind               = kind;
      row.data               = data;
      row.check              = check;
      row.given.result_kind  = rkind;
      row.given.payload_byte = rbyte;
      row.given.frame_good   = rgood;
      script = {script, row};
   endtask

   // result checker and receiver stalls
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            note_mismatch($sformatf("result with nothing expected: kind %0d byte %02h good %0d",
                                    rsp_tuser, rsp_tdata[7:0], rsp_tdata[8]));
         end else begin
            result_type want;
            want = expected_results.pop_front();
            if (rsp_tuser !== want.result_kind || rsp_tdata[7:0] !== want.payload_byte ||
                rsp_tdata[8] !== want.frame_good)
               note_mismatch($sformatf("kind %0d/%0d byte %02h/%02h good %0d/%0d (exp/got)",
                                       want.result_kind, rsp_tuser, want.payload_byte,
                                       rsp_tdata[7:0], want.frame_good, rsp_tdata[8]));
         end
      end
      if (hold_cycles > 0) begin
         hold_cycles = hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      bit         has_result;
      result_type res;

      // release while hunting, then a good two-byte frame with the extreme payload bytes
      add_row(KIND_RELEASE, 8'h00, CHECK_NONE);
      add_row(KIND_BYTE, 8'hAA, CHECK_PREDICTED);
      add_row(KIND_BYTE, 8'h55, CHECK_PREDICTED);
      add_row(KIND_BYTE, 8'h00, CHECK_PREDICTED);
      add_row(KIND_BYTE, 8'h02, CHECK_PREDICTED);
      add_row(KIND_BYTE, 8'hFF, CHECK_GIVEN, RES_PAYLOAD, 8'hFF, 1'b0);
      add_row(KIND_BYTE, 8'h00, CHECK_GIVEN, RES_PAYLOAD, 8'h00, 1'b0);
      add_row(KIND_BYTE, 8'h00, CHECK_PREDICTED);
      add_row(KIND_BYTE, 8'h00, CHECK_GIVEN, RES_FRAME_END, 8'h00, 1'b1);
      // byte while holding is dropped, release while holding
      add_row(KIND_BYTE, 8'hAA, CHECK_NONE);
      add_row(KIND_RELEASE, 8'hFF, CHECK_NONE);
      // zero length frame with a bad checksum
      add_row(KIND_BYTE, 8'hAA, CHECK_PREDICTED);
      add_row(KIND_BYTE, 8'h55, CHECK_PREDICTED);
      add_row(KIND_BYTE, 8'h00, CHECK_PREDICTED);
      add_row(KIND_BYTE, 8'h00, CHECK_PREDICTED);
      add_row(KIND_BYTE, 8'h12, CHECK_PREDICTED);
      add_row(KIND_BYTE, 8'h34, CHECK_GIVEN, RES_FRAME_END, 8'h00, 1'b0);
      // wrong second start byte is not taken as a new first start byte
      add_row(KIND_BYTE, 8'hAA, CHECK_NONE);
      add_row(KIND_BYTE, 8'hAA, CHECK_NONE);
      add_row(KIND_BYTE, 8'h55, CHECK_NONE);
      add_row(KIND_BYTE, 8'h00, CHECK_NONE);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         send_beat(script[i].kind, script[i].data, has_result, res);
         case (script[i].check)
            CHECK_PREDICTED: if (has_result) expected_results = {expected_results, res};
            CHECK_GIVEN:     expected_results = {expected_results, script[i].given};
            default: ;
         endcase
      end

      for (int p = 0; p < 4; p++) begin
         wait_drained();
         items_counted = 0;
         case (p)
            0: begin
               set_start_bytes(8'h00, 8'hFF);
               send_idle_pct  = 0;
               recv_stall_pct = 0;
               // long receiver hold-off while beats keep coming
               hold_cycles = 200;
            end
            1: begin
               set_start_bytes(8'hFF, 8'h00);
               send_idle_pct  = 74;
               recv_stall_pct = 0;
            end
            2: begin
               set_start_bytes(8'($urandom), 8'($urandom));
               send_idle_pct  = 0;
               recv_stall_pct = 74;
            end
            default: begin
               set_start_bytes(8'h7E, 8'h7E);
               send_idle_pct  = 24;
               recv_stall_pct = 24;
            end
         endcase
         run_random(PHASE_ITEMS / 2);
         if (p == 1)
            wait_drained();
         run_random(PHASE_ITEMS);
      end

      wait_drained();
      if (mismatches == 0 && expected_results.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/sofrx_pkg.sv
rtl/core/sofrx_in_stage.sv
rtl/core/sofrx_parse.sv
rtl/core/sofrx_out_stage.sv
rtl/core/sof_length_frame_receiver.sv
tb/sof_length_frame_receiver_test.sv
